// File: hdl/hrp_pkg.sv
// Package for the H.264 RTP packetizer: queue entry type, state enums,
// register indexes and header constants.
// No dependencies.
package hrp_pkg;

	localparam int LENGTH_BITS_DEF = 16;
	localparam int QUEUE_DEPTH     = 4;
	localparam int HDR_LEN         = 12;

	localparam logic [1:0]  REG_SSRC         = 2'd0;
	localparam logic [1:0]  REG_PAYLOAD_TYPE = 2'd1;
	localparam logic [1:0]  REG_MAX_PAYLOAD  = 2'd2;

	localparam logic [31:0] SSRC_RST         = 32'd0;
	localparam logic [6:0]  PAYLOAD_TYPE_RST = 7'd96;
	localparam logic [11:0] MAX_PAYLOAD_RST  = 12'd1400;
	localparam logic [11:0] MIN_PAYLOAD      = 12'd16;

	localparam logic [7:0]  RTP_VER_BYTE = 8'h80;
	localparam logic [7:0]  FU_A_TYPE    = 8'd28;
	localparam logic [7:0]  NRI_MASK     = 8'hE0;
	localparam logic [7:0]  TYPE_MASK    = 8'h1F;
	localparam logic [7:0]  FU_START     = 8'h80;
	localparam logic [7:0]  FU_END       = 8'h40;
	localparam logic [15:0] FIDX_MAX     = 16'hFFFF;

	// held count codes beyond the hold phase
	localparam logic [2:0]  HC_DONE     = 3'd4;
	localparam logic [2:0]  HC_WAIT_HDR = 3'd5;

	typedef enum logic {OP_HDR, OP_BYTE} op_kind_t;

	typedef struct packed {
		op_kind_t    kind;
		logic [7:0]  data;
		logic        pkt_last;
		logic        run_last;
		logic [31:0] ts;
	} op_t;

	typedef enum logic {F_IDLE, F_RUN} front_state_t;

	typedef enum logic [2:0] {PH_SHDR, PH_FHDR, PH_FIND, PH_FFUH, PH_DATA} phase_t;

	typedef enum logic {BK_OP, BK_HDR} back_state_t;

endpackage

// File: hdl/hrp_front.sv
// Front end: accepts NAL bytes, holds the first four, strips the start code,
// picks single or FU-A mode and queues header and byte requests.
// Depends on hrp_pkg.
module hrp_front #(
	parameter int LENGTH_BITS = hrp_pkg::LENGTH_BITS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	output logic         in_ready,
	input  logic [7:0]   data_byte,
	input  logic [15:0]  nal_length,
	input  logic [31:0]  timestamp,
	input  logic         first_of_nal,
	input  logic [11:0]  max_payload,
	output logic         push,
	output hrp_pkg::op_t push_op,
	input  logic         full
);
	import hrp_pkg::*;

	localparam int LB  = LENGTH_BITS;
	localparam int EXT = (LB > 16) ? LB : 16;
	localparam int CW  = ((LB > 12) ? LB : 12) + 1;

	front_state_t    state_q, state_d;
	phase_t          phase_q, phase_d;
	logic [7:0]      held_q [4];
	logic [7:0]      held_d [4];
	logic [2:0]      hc_q, hc_d;
	logic [LB-1:0]   rem_q, rem_d;
	logic [7:0]      nhdr_q, nhdr_d;
	logic            frag_q, frag_d;
	logic [11:0]     fill_q, fill_d;
	logic [15:0]     fidx_q, fidx_d;
	logic [31:0]     ts_q, ts_d;
	logic [2:0]      i_q, i_d;
	logic [2:0]      n_q, n_d;
	logic            slast_q, slast_d;

	logic [11:0]     m_eff;
	logic [EXT-1:0]  len_ext;
	logic [LB-1:0]   rem_in;
	logic [2:0]      strip;
	logic [CW-1:0]   len_c;
	logic [LB-1:0]   left_c;
	logic            final_c;
	logic [7:0]      fuh;
	logic [11:0]     fill1;
	logic            plast;

	assign m_eff   = (max_payload < MIN_PAYLOAD) ? MIN_PAYLOAD : max_payload;
	assign len_ext = EXT'(nal_length);
	assign rem_in  = len_ext[LB-1:0];
	assign left_c  = rem_q + LB'(n_q - 3'd1 - i_q);
	assign final_c = (i_q == n_q - 3'd1);

	always_comb begin
		state_d  = state_q;
		phase_d  = phase_q;
		held_d   = held_q;
		hc_d     = hc_q;
		rem_d    = rem_q;
		nhdr_d   = nhdr_q;
		frag_d   = frag_q;
		fill_d   = fill_q;
		fidx_d   = fidx_q;
		ts_d     = ts_q;
		i_d      = i_q;
		n_d      = n_q;
		slast_d  = slast_q;
		strip    = 3'd0;
		len_c    = '0;
		fuh      = '0;
		fill1    = fill_q + 12'd1;
		plast    = 1'b0;
		push     = 1'b0;
		push_op  = '0;
		in_ready = (state_q == F_IDLE);
		case (state_q)
			F_IDLE: begin
				if (in_valid) begin
					if (first_of_nal) begin
						hc_d   = 3'd0;
						rem_d  = rem_in;
						ts_d   = timestamp;
						frag_d = 1'b0;
						fill_d = '0;
						fidx_d = '0;
						nhdr_d = '0;
					end
					if (rem_d != '0) begin
						rem_d = rem_d - 1'b1;
						if (hc_d < HC_DONE) begin
							held_d[hc_d[1:0]] = data_byte;
							n_d  = hc_d + 3'd1;
							hc_d = n_d;
							if (n_d == HC_DONE || rem_d == '0) begin
								if (n_d >= 3'd3 && held_d[0] == 8'd0 && held_d[1] == 8'd0
									&& held_d[2] == 8'd1)
									strip = 3'd3;
								else if (n_d == 3'd4 && held_d[0] == 8'd0 && held_d[1] == 8'd0
									&& held_d[2] == 8'd0 && held_d[3] == 8'd1)
									strip = 3'd4;
								len_c = CW'(n_d - strip) + CW'(rem_d);
								hc_d  = HC_DONE;
								if (len_c <= CW'(m_eff)) begin
									frag_d  = 1'b0;
									slast_d = (len_c == '0);
									i_d     = strip;
									phase_d = PH_SHDR;
									state_d = F_RUN;
								end else begin
									frag_d = 1'b1;
									if (strip >= n_d) begin
										hc_d = HC_WAIT_HDR;
									end else begin
										nhdr_d = held_d[strip[1:0]];
										i_d    = strip + 3'd1;
										if (i_d < n_d) begin
											phase_d = (fill_d == '0) ? PH_FHDR : PH_DATA;
											state_d = F_RUN;
										end
									end
								end
							end
						end else if (hc_d == HC_WAIT_HDR) begin
							nhdr_d = data_byte;
							hc_d   = HC_DONE;
						end else begin
							held_d[0] = data_byte;
							i_d       = 3'd0;
							n_d       = 3'd1;
							phase_d   = (frag_d && fill_d == '0) ? PH_FHDR : PH_DATA;
							state_d   = F_RUN;
						end
					end
				end
			end
			F_RUN: begin
				if (!full) begin
					push = 1'b1;
					case (phase_q)
						PH_SHDR: begin
							push_op.kind     = OP_HDR;
							push_op.ts       = ts_q;
							push_op.pkt_last = slast_q;
							push_op.run_last = (i_q == n_q);
							if (i_q == n_q)
								state_d = F_IDLE;
							else
								phase_d = PH_DATA;
						end
						PH_FHDR: begin
							push_op.kind = OP_HDR;
							push_op.ts   = ts_q;
							phase_d      = PH_FIND;
						end
						PH_FIND: begin
							push_op.kind = OP_BYTE;
							push_op.data = (nhdr_q & NRI_MASK) | FU_A_TYPE;
							phase_d      = PH_FFUH;
						end
						PH_FFUH: begin
							fuh = nhdr_q & TYPE_MASK;
							if (fidx_q == '0)
								fuh = fuh | FU_START;
							else if (CW'(left_c) + CW'(1) <= CW'(m_eff))
								fuh = fuh | FU_END;
							push_op.kind = OP_BYTE;
							push_op.data = fuh;
							phase_d      = PH_DATA;
						end
						default: begin
							if (frag_q) begin
								plast  = (fill1 >= m_eff) || (left_c == '0);
								fill_d = plast ? 12'd0 : fill1;
								if (plast && fidx_q < FIDX_MAX)
									fidx_d = fidx_q + 16'd1;
							end else begin
								plast = (left_c == '0);
							end
							push_op.kind     = OP_BYTE;
							push_op.data     = held_q[i_q[1:0]];
							push_op.pkt_last = plast;
							push_op.run_last = final_c;
							if (final_c) begin
								state_d = F_IDLE;
							end else begin
								i_d     = i_q + 3'd1;
								phase_d = (frag_q && fill_d == '0) ? PH_FHDR : PH_DATA;
							end
						end
					endcase
				end
			end
			default: state_d = F_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			phase_q <= PH_DATA;
			hc_q    <= '0;
			rem_q   <= '0;
			nhdr_q  <= '0;
			frag_q  <= 1'b0;
			fill_q  <= '0;
			fidx_q  <= '0;
			ts_q    <= '0;
			i_q     <= '0;
			n_q     <= '0;
			slast_q <= 1'b0;
		end else begin
			state_q <= state_d;
			phase_q <= phase_d;
			hc_q    <= hc_d;
			rem_q   <= rem_d;
			nhdr_q  <= nhdr_d;
			frag_q  <= frag_d;
			fill_q  <= fill_d;
			fidx_q  <= fidx_d;
			ts_q    <= ts_d;
			i_q     <= i_d;
			n_q     <= n_d;
			slast_q <= slast_d;
		end
	end

	always_ff @(posedge clk) begin
		held_q <= held_d;
	end

endmodule

// File: hdl/hrp_fifo.sv
// Short request queue between the front end and the packet writer.
// Depends on hrp_pkg.
module hrp_fifo (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  hrp_pkg::op_t push_op,
	output logic         full,
	input  logic         pop,
	output hrp_pkg::op_t pop_op,
	output logic         empty
);
	import hrp_pkg::*;

	localparam int AW = $clog2(QUEUE_DEPTH);
	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	op_t           mem_q [QUEUE_DEPTH];
	logic [AW-1:0] wr_q, rd_q;
	logic [CW-1:0] cnt_q;
	logic          do_push, do_pop;

	assign full    = (cnt_q == CW'(QUEUE_DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign pop_op  = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push)
				wr_q <= (wr_q == AW'(QUEUE_DEPTH - 1)) ? '0 : wr_q + 1'b1;
			if (do_pop)
				rd_q <= (rd_q == AW'(QUEUE_DEPTH - 1)) ? '0 : rd_q + 1'b1;
			if (do_push && !do_pop)
				cnt_q <= cnt_q + 1'b1;
			else if (do_pop && !do_push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wr_q] <= push_op;
	end

endmodule

// File: hdl/hrp_back.sv
// Packet writer: expands queued requests into RTP header and payload bytes,
// keeps the sequence number and drives the output register.
// Depends on hrp_pkg.
module hrp_back (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         empty,
	input  hrp_pkg::op_t pop_op,
	output logic         pop,
	input  logic [31:0]  ssrc,
	input  logic [6:0]   payload_type,
	output logic         out_valid,
	input  logic         out_ready,
	output logic [7:0]   out_byte,
	output logic         packet_first,
	output logic         packet_last,
	output logic         run_last
);
	import hrp_pkg::*;

	localparam int HW = $clog2(HDR_LEN);

	back_state_t   st_q, st_d;
	op_t           cur_q, cur_d;
	logic [HW-1:0] hcnt_q, hcnt_d;
	logic [15:0]   seq_q, seq_d;
	logic          ov_q, ov_d;
	logic [7:0]    ob_q, ob_d;
	logic          of_q, of_d;
	logic          ol_q, ol_d;
	logic          orun_q, orun_d;
	logic          load;
	logic [7:0]    hdr_byte;

	assign load         = !ov_q || out_ready;
	assign out_valid    = ov_q;
	assign out_byte     = ob_q;
	assign packet_first = of_q;
	assign packet_last  = ol_q;
	assign run_last     = orun_q;

	always_comb begin
		case (hcnt_q)
			HW'(1):  hdr_byte = {1'b0, payload_type};
			HW'(2):  hdr_byte = seq_q[15:8];
			HW'(3):  hdr_byte = seq_q[7:0];
			HW'(4):  hdr_byte = cur_q.ts[31:24];
			HW'(5):  hdr_byte = cur_q.ts[23:16];
			HW'(6):  hdr_byte = cur_q.ts[15:8];
			HW'(7):  hdr_byte = cur_q.ts[7:0];
			HW'(8):  hdr_byte = ssrc[31:24];
			HW'(9):  hdr_byte = ssrc[23:16];
			HW'(10): hdr_byte = ssrc[15:8];
			HW'(11): hdr_byte = ssrc[7:0];
			default: hdr_byte = RTP_VER_BYTE;
		endcase
	end

	always_comb begin
		st_d   = st_q;
		cur_d  = cur_q;
		hcnt_d = hcnt_q;
		seq_d  = seq_q;
		ov_d   = ov_q && !out_ready;
		ob_d   = ob_q;
		of_d   = of_q;
		ol_d   = ol_q;
		orun_d = orun_q;
		pop    = 1'b0;
		case (st_q)
			BK_OP: begin
				if (load && !empty) begin
					pop  = 1'b1;
					ov_d = 1'b1;
					if (pop_op.kind == OP_HDR) begin
						ob_d   = RTP_VER_BYTE;
						of_d   = 1'b1;
						ol_d   = 1'b0;
						orun_d = 1'b0;
						seq_d  = seq_q + 16'd1;
						cur_d  = pop_op;
						hcnt_d = HW'(1);
						st_d   = BK_HDR;
					end else begin
						ob_d   = pop_op.data;
						of_d   = 1'b0;
						ol_d   = pop_op.pkt_last;
						orun_d = pop_op.run_last;
					end
				end
			end
			BK_HDR: begin
				if (load) begin
					ov_d = 1'b1;
					ob_d = hdr_byte;
					of_d = 1'b0;
					if (hcnt_q == HW'(HDR_LEN - 1)) begin
						ol_d   = cur_q.pkt_last;
						orun_d = cur_q.run_last;
						st_d   = BK_OP;
					end else begin
						ol_d   = 1'b0;
						orun_d = 1'b0;
						hcnt_d = hcnt_q + 1'b1;
					end
				end
			end
			default: st_d = BK_OP;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= BK_OP;
			hcnt_q <= '0;
			seq_q  <= '0;
			ov_q   <= 1'b0;
		end else begin
			st_q   <= st_d;
			hcnt_q <= hcnt_d;
			seq_q  <= seq_d;
			ov_q   <= ov_d;
		end
	end

	always_ff @(posedge clk) begin
		cur_q  <= cur_d;
		ob_q   <= ob_d;
		of_q   <= of_d;
		ol_q   <= ol_d;
		orun_q <= orun_d;
	end

endmodule

// File: hdl/h264_rtp_packetizer.sv
// Top level of the H.264 RTP packetizer with FU-A fragmentation.
// Holds the configuration registers; depends on hrp_pkg, hrp_front, hrp_fifo, hrp_back.
//
// channel   dir  tdata / tuser / tlast
// s_axis    in   tdata: data_byte[7:0] nal_length[23:8] timestamp[55:24]; tuser: first_of_nal
// m_axis    out  tdata: out_byte[7:0]; tuser: packet_first[0] run_last[1]; tlast: packet_last
// cfg       in   cfg_index 0 ssrc, 1 payload_type, 2 max_payload
//
// An input byte is taken, then its requests are queued one per cycle unless the
// queue is full (one per plain byte, four if it opens an FU-A fragment, up to six
// after the start-code decision); the next byte is taken once the front end is idle.
// The output register moves one byte per cycle unless stalled; headers are twelve bytes.
// Reset clears control state and the sequence number; no clearing pass.
// A stalled output fills the four-entry queue and then holds s_axis_tready low.
module h264_rtp_packetizer #(
	parameter int LENGTH_BITS = hrp_pkg::LENGTH_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [55:0] s_axis_tdata,   // data_byte, nal_length, timestamp
	input  logic        s_axis_tuser,   // first_of_nal
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [7:0]  m_axis_tdata,   // out_byte
	output logic        m_axis_tlast,
	output logic [1:0]  m_axis_tuser,   // packet_first, run_last
	input  logic        cfg_wr_en,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data
);
	import hrp_pkg::*;

	logic [31:0] ssrc_q;
	logic [6:0]  pt_q;
	logic [11:0] maxp_q;
	logic        push, full, pop, empty;
	op_t         push_op, pop_op;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ssrc_q <= SSRC_RST;
			pt_q   <= PAYLOAD_TYPE_RST;
			maxp_q <= MAX_PAYLOAD_RST;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_SSRC:         ssrc_q <= cfg_data;
				REG_PAYLOAD_TYPE: pt_q   <= cfg_data[6:0];
				REG_MAX_PAYLOAD:  maxp_q <= cfg_data[11:0];
				default: ;
			endcase
		end
	end

	hrp_front #(
		.LENGTH_BITS(LENGTH_BITS)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (s_axis_tvalid),
		.in_ready    (s_axis_tready),
		.data_byte   (s_axis_tdata[7:0]),
		.nal_length  (s_axis_tdata[23:8]),
		.timestamp   (s_axis_tdata[55:24]),
		.first_of_nal(s_axis_tuser),
		.max_payload (maxp_q),
		.push        (push),
		.push_op     (push_op),
		.full        (full)
	);

	hrp_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.push_op(push_op),
		.full   (full),
		.pop    (pop),
		.pop_op (pop_op),
		.empty  (empty)
	);

	hrp_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.empty       (empty),
		.pop_op      (pop_op),
		.pop         (pop),
		.ssrc        (ssrc_q),
		.payload_type(pt_q),
		.out_valid   (m_axis_tvalid),
		.out_ready   (m_axis_tready),
		.out_byte    (m_axis_tdata),
		.packet_first(m_axis_tuser[0]),
		.packet_last (m_axis_tlast),
		.run_last    (m_axis_tuser[1])
	);

endmodule
